/* rtl/weighted_round_robin_multi_queue_assert.svh */
// Assertion macros shared by the weighted round robin multi-queue RTL
`ifndef WEIGHTED_ROUND_ROBIN_MULTI_QUEUE_ASSERT_SVH
`define WEIGHTED_ROUND_ROBIN_MULTI_QUEUE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define WRRMQ_CHECK(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("wrrmq: check failed");

// same-cycle implication
`define WRRMQ_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wrrmq: implication failed");

// next-cycle implication
`define WRRMQ_IMPLY_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wrrmq: next-cycle implication failed");

`endif

/* rtl/wrrmq_pkg.sv */
// Types and constants for the weighted round robin multi-queue
`timescale 1ns / 1ps

package wrrmq_pkg;

    localparam int DEF_NUM_QUEUES  = 4;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int MSG_W          = 32;
    localparam int QID_W          = 2;
    localparam int WEIGHT_W       = 8;
    localparam int NUM_CFG_QUEUES = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Q0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Q1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Q2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Q3    = 3'd4;

    typedef enum logic {
        FUNC_PUT = 1'b0,
        FUNC_GET = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_DISABLED = 2'd3
    } t_status;

    typedef struct packed {
        t_func              func;
        logic [QID_W-1:0]   queue_id;
        logic [MSG_W-1:0]   message;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [MSG_W-1:0]   message_out;
        logic [QID_W-1:0]   served_queue;
        logic               ready_pulse;
    } t_out_item;

endpackage

/* rtl/wrrmq_ram.sv */
// Simple dual-port RAM, one write and one registered read port
`timescale 1ns / 1ps

module wrrmq_ram #(
    parameter  int WIDTH = wrrmq_pkg::MSG_W,
    parameter  int DEPTH = wrrmq_pkg::DEF_NUM_QUEUES * wrrmq_pkg::DEF_QUEUE_DEPTH,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/wrrmq_pick.sv */
// Rotating priority encoder: first request after a base index, wrapping
`timescale 1ns / 1ps

module wrrmq_pick #(
    parameter  int NUM_QUEUES = wrrmq_pkg::DEF_NUM_QUEUES,
    localparam int QW         = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
    input  logic [NUM_QUEUES-1:0] i_req,
    input  logic [QW-1:0]         i_base,
    output logic                  o_found,
    output logic [QW-1:0]         o_idx
);

    always_comb begin
        logic [QW:0] pos;
        o_found = 1'b0;
        o_idx   = i_base;
        // highest offset first so the nearest request wins
        for (int k = NUM_QUEUES - 1; k >= 1; k--) begin
            pos = {1'b0, i_base} + (QW + 1)'(k);
            if (pos >= (QW + 1)'(NUM_QUEUES)) begin
                pos = pos - (QW + 1)'(NUM_QUEUES);
            end
            if (i_req[pos[QW-1:0]]) begin
                o_found = 1'b1;
                o_idx   = pos[QW-1:0];
            end
        end
    end

endmodule

/* rtl/weighted_round_robin_multi_queue.sv */
// Top level: weighted round robin multi-queue with put/get command channel
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_in_data) carries put and get
//   commands. Every command returns exactly one result beat on the output
//   channel (o_out_valid / i_out_ready, o_out_data).
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data)
//   is always ready; write it only while no command is in flight.
//   A command beat is held in the command stage, then its result in the result register.
//   Throughput: one command per cycle unless the receiver stalls; each command
//   is decided in one pass through the stage register, at most one RAM access.
//   Reset: all queues empty, consumer idle, all queues enabled, weights one.
//   The message RAM is not cleared; it is only read at written entries.
//   Receiver stall: the result register holds its beat; o_in_ready drops once
//   the command stage is also occupied, and rises again as soon as the
//   result is taken.
`timescale 1ns / 1ps

`include "weighted_round_robin_multi_queue_assert.svh"

module weighted_round_robin_multi_queue #(
    parameter int NUM_QUEUES  = wrrmq_pkg::DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = wrrmq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  wrrmq_pkg::t_in_item                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output wrrmq_pkg::t_out_item                o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wrrmq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wrrmq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import wrrmq_pkg::*;

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    typedef struct packed {
        logic          lap;
        logic [IW-1:0] idx;
    } t_ptr;

    function automatic t_ptr f_ptr_inc(t_ptr p);
        t_ptr r;
        r = p;
        if (p.idx == IW'(QUEUE_DEPTH - 1)) begin
            r.idx = '0;
            r.lap = ~p.lap;
        end else begin
            r.idx = p.idx + 1'b1;
        end
        return r;
    endfunction

    // configuration
    logic [NUM_CFG_QUEUES-1:0] r_queue_enable;
    logic [WEIGHT_W-1:0]       r_weight [NUM_CFG_QUEUES];

    // command stage
    logic     r_s1_valid;
    t_in_item r_s1;

    // queue state
    t_ptr          r_rd  [NUM_QUEUES];
    t_ptr          r_wr  [NUM_QUEUES];
    logic [WEIGHT_W-1:0] r_wc [NUM_QUEUES];
    logic [QW-1:0] r_cur;
    logic          r_idle;
    t_ptr          n_rd  [NUM_QUEUES];
    t_ptr          n_wr  [NUM_QUEUES];
    logic [WEIGHT_W-1:0] n_wc [NUM_QUEUES];
    logic [QW-1:0] n_cur;
    logic          n_idle;

    // result register
    logic    r_out_valid;
    t_status r_out_status;
    logic    r_out_get;
    logic [QID_W-1:0] r_out_served;
    logic    r_out_pulse;
    t_status n_status;
    logic [QID_W-1:0] n_served;
    logic    n_pulse;

    logic in_fire, out_free, s1_fire;

    logic [NUM_QUEUES-1:0] en_vec, empty_vec, full_vec, rdy;
    logic [WEIGHT_W-1:0]   w_vec [NUM_QUEUES];

    logic          put_in_range, put_en;
    logic [QW-1:0] qid_q;
    logic          found0, do_scan, scan_found, get_found;
    logic [QW-1:0] scan_idx, q_s, next_idx;
    logic          next_found;
    logic [WEIGHT_W-1:0] wc_inc, w_eff;
    logic          turn_end;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [MSG_W-1:0] ram_rdata;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_enable <= '1;
            for (int i = 0; i < NUM_CFG_QUEUES; i++) begin
                r_weight[i] <= WEIGHT_W'(1);
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_QUEUE_ENABLE: r_queue_enable <= i_cfg_data[NUM_CFG_QUEUES-1:0];
                CFG_WEIGHT_Q0:    r_weight[0] <= i_cfg_data;
                CFG_WEIGHT_Q1:    r_weight[1] <= i_cfg_data;
                CFG_WEIGHT_Q2:    r_weight[2] <= i_cfg_data;
                CFG_WEIGHT_Q3:    r_weight[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-queue flags; queues beyond the register set are always on, weight one
    for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_queue
        if (g < NUM_CFG_QUEUES) begin : g_cfg
            assign en_vec[g] = r_queue_enable[g];
            assign w_vec[g]  = r_weight[g];
        end else begin : g_fixed
            assign en_vec[g] = 1'b1;
            assign w_vec[g]  = WEIGHT_W'(1);
        end
        assign empty_vec[g] = (r_rd[g] == r_wr[g]);
        assign full_vec[g]  = (r_rd[g].idx == r_wr[g].idx) && (r_rd[g].lap != r_wr[g].lap);
    end

    assign rdy = en_vec & ~empty_vec;

    // put decode
    assign qid_q        = QW'(r_s1.queue_id);
    assign put_in_range = (int'(r_s1.queue_id) < NUM_QUEUES);
    assign put_en       = put_in_range && en_vec[qid_q];

    // get decode
    assign found0  = rdy[r_cur];
    assign do_scan = !found0 && !r_idle;

    wrrmq_pick #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_scan (
        .i_req   (rdy),
        .i_base  (r_cur),
        .o_found (scan_found),
        .o_idx   (scan_idx)
    );

    assign get_found = found0 || (do_scan && scan_found);
    assign q_s       = found0 ? r_cur : scan_idx;

    wrrmq_pick #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_next (
        .i_req   (en_vec),
        .i_base  (q_s),
        .o_found (next_found),
        .o_idx   (next_idx)
    );

    assign wc_inc   = r_wc[q_s] + 1'b1;
    assign w_eff    = (w_vec[q_s] == '0) ? WEIGHT_W'(1) : w_vec[q_s];
    assign turn_end = (wc_inc >= w_eff);

    assign ram_waddr = AW'(int'(qid_q) * QUEUE_DEPTH + int'(r_wr[qid_q].idx));
    assign ram_raddr = AW'(int'(q_s) * QUEUE_DEPTH + int'(r_rd[q_s].idx));

    always_comb begin
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_wc     = r_wc;
        n_cur    = r_cur;
        n_idle   = r_idle;
        n_status = ST_OK;
        n_served = '0;
        n_pulse  = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        if (s1_fire) begin
            case (r_s1.func)
                FUNC_PUT: begin
                    if (!put_en) begin
                        n_status = ST_DISABLED;
                    end else if (full_vec[qid_q]) begin
                        n_status = ST_FULL;
                    end else begin
                        ram_we       = 1'b1;
                        n_wr[qid_q]  = f_ptr_inc(r_wr[qid_q]);
                        if (r_idle) begin
                            n_idle  = 1'b0;
                            n_pulse = 1'b1;
                        end
                    end
                end
                FUNC_GET: begin
                    if (!get_found) begin
                        n_status = ST_EMPTY;
                        n_idle   = 1'b1;
                    end else begin
                        ram_re    = 1'b1;
                        n_idle    = 1'b0;
                        n_served  = QID_W'(q_s);
                        n_rd[q_s] = f_ptr_inc(r_rd[q_s]);
                        if (turn_end) begin
                            n_wc[q_s] = '0;
                            n_cur     = next_found ? next_idx : q_s;
                        end else begin
                            n_wc[q_s] = wc_inc;
                            n_cur     = q_s;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            r_idle      <= 1'b1;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_rd[i] <= '0;
                r_wr[i] <= '0;
                r_wc[i] <= '0;
            end
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_rd   <= n_rd;
            r_wr   <= n_wr;
            r_wc   <= n_wc;
            r_cur  <= n_cur;
            r_idle <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in_data;
        end
        if (s1_fire) begin
            r_out_status <= n_status;
            r_out_get    <= (r_s1.func == FUNC_GET);
            r_out_served <= n_served;
            r_out_pulse  <= n_pulse;
        end
    end

    wrrmq_ram #(
        .WIDTH (MSG_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_s1.message),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid             = r_out_valid;
    assign o_out_data.status       = r_out_status;
    assign o_out_data.message_out  = (r_out_get && r_out_status == ST_OK) ? ram_rdata : '0;
    assign o_out_data.served_queue = r_out_served;
    assign o_out_data.ready_pulse  = r_out_pulse;

    `WRRMQ_CHECK(a_cur_in_range, int'(r_cur) < NUM_QUEUES)
    `WRRMQ_CHECK(a_ram_single_access, !(ram_we && ram_re))
    `WRRMQ_IMPLY(a_serve_ready_queue, ram_re, rdy[q_s])
    `WRRMQ_IMPLY_NEXT(a_miss_sets_idle, s1_fire && r_s1.func == FUNC_GET && !get_found, r_idle)
    `WRRMQ_IMPLY(a_pulse_on_put_ok, o_out_valid && o_out_data.ready_pulse, o_out_data.status == ST_OK && !r_out_get)

endmodule

/* tb/sv/wrrmq_service_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the weighted round robin multi-queue: predicts every result beat and compares it

module wrrmq_service_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  wrrmq_pkg::t_in_item              i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  wrrmq_pkg::t_out_item             i_out_data,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [wrrmq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wrrmq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                               o_failures,
    output int                               o_pending
);

    import wrrmq_pkg::*;

    localparam int NQ       = DEF_NUM_QUEUES;
    localparam int DEPTH    = DEF_QUEUE_DEPTH;
    localparam int PTR_WRAP = 2 * DEPTH;

    logic [NQ-1:0]       enable_mask;
    logic [WEIGHT_W-1:0] turn_weight [NQ];
    logic [MSG_W-1:0]    msg_store [NQ][DEPTH];
    int                  rd_ptr [NQ];
    int                  wr_ptr [NQ];
    logic [7:0]          served_in_turn [NQ];
    int                  active_queue;
    bit                  consumer_idle;
    t_out_item           expected_results [$];
    int                  failures = 0;
    int                  pending_beats = 0;

    assign o_failures = failures;
    assign o_pending  = pending_beats;

    function automatic int fill_of(int q);
        return (wr_ptr[q] - rd_ptr[q] + PTR_WRAP) % PTR_WRAP;
    endfunction

    function automatic bit has_work(int q);
        return enable_mask[q] && fill_of(q) != 0;
    endfunction

    function automatic int next_in_turn(int q);
        for (int k = 1; k <= NQ; k++) begin
            if (enable_mask[(q + k) % NQ]) return (q + k) % NQ;
        end
        return q;
    endfunction

    function automatic t_out_item apply_command(t_in_item cmd);
        t_out_item res;
        int        q;
        int        limit;
        bit        found;
        res        = '0;
        res.status = ST_OK;
        if (cmd.func == FUNC_PUT) begin
            q = int'(cmd.queue_id);
            if (q >= NQ || !enable_mask[q]) begin
                res.status = ST_DISABLED;
            end else if (fill_of(q) >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                msg_store[q][wr_ptr[q] % DEPTH] = cmd.message;
                wr_ptr[q] = (wr_ptr[q] + 1) % PTR_WRAP;
                if (consumer_idle) begin
                    consumer_idle   = 1'b0;
                    res.ready_pulse = 1'b1;
                end
            end
        end else begin
            q     = active_queue;
            found = has_work(q);
            // scan only from an awake consumer; it goes idle first
            if (!found && !consumer_idle) begin
                consumer_idle = 1'b1;
                for (int k = 1; k < NQ && !found; k++) begin
                    if (has_work((active_queue + k) % NQ)) begin
                        q     = (active_queue + k) % NQ;
                        found = 1'b1;
                    end
                end
            end
            if (!found) begin
                res.status = ST_EMPTY;
            end else begin
                limit            = (turn_weight[q] == '0) ? 1 : int'(turn_weight[q]);
                consumer_idle    = 1'b0;
                res.message_out  = msg_store[q][rd_ptr[q] % DEPTH];
                res.served_queue = QID_W'(q);
                rd_ptr[q]        = (rd_ptr[q] + 1) % PTR_WRAP;
                served_in_turn[q] = served_in_turn[q] + 8'd1;
                if (served_in_turn[q] >= limit) begin
                    served_in_turn[q] = '0;
                    q = next_in_turn(q);
                end
                active_queue = q;
            end
        end
        return res;
    endfunction

    task automatic check_field(string field, logic [MSG_W-1:0] want, logic [MSG_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            enable_mask = '1;
            for (int q = 0; q < NQ; q++) begin
                turn_weight[q]    = 8'd1;
                rd_ptr[q]         = 0;
                wr_ptr[q]         = 0;
                served_in_turn[q] = '0;
            end
            active_queue  = 0;
            consumer_idle = 1'b1;
            expected_results.delete();
            pending_beats <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result beat 0x%0h with nothing expected",
                             $time, i_out_data);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", MSG_W'(want.status), MSG_W'(i_out_data.status));
                    check_field("message_out", want.message_out, i_out_data.message_out);
                    check_field("served_queue", MSG_W'(want.served_queue),
                                MSG_W'(i_out_data.served_queue));
                    check_field("ready_pulse", MSG_W'(want.ready_pulse),
                                MSG_W'(i_out_data.ready_pulse));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_QUEUE_ENABLE: enable_mask    = i_cfg_data[NQ-1:0];
                    CFG_WEIGHT_Q0:    turn_weight[0] = i_cfg_data;
                    CFG_WEIGHT_Q1:    turn_weight[1] = i_cfg_data;
                    CFG_WEIGHT_Q2:    turn_weight[2] = i_cfg_data;
                    CFG_WEIGHT_Q3:    turn_weight[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_command(i_in_data));
            end
            pending_beats <= expected_results.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Top of the weighted round robin multi-queue testbench: clock, reset, stimulus and verdict

module testbench;
    import wrrmq_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 250;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  cfg_ready;
    int                    failures;
    int                    pending;
    int                    cycle_count = 0;
    int                    beats_taken = 0;
    int                    rx_stall    = 0;

    weighted_round_robin_multi_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    wrrmq_service_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: short random stalls, idle-free stretches, two long hold-offs
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                beats_taken = beats_taken + 1;
                if (beats_taken == 300 || beats_taken == 900) begin
                    rx_stall = 120;
                end else if (rx_stall == 0 && ((beats_taken / 250) % 3) != 1) begin
                    rx_stall = pick_gap();
                end
            end
            if (rx_stall > 0) begin
                rx_stall = rx_stall - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic t_in_item make_cmd(t_func f, logic [QID_W-1:0] q, logic [MSG_W-1:0] m);
        t_in_item cmd;
        cmd.func     = f;
        cmd.queue_id = q;
        cmd.message  = m;
        return cmd;
    endfunction

    function automatic logic [3:0][WEIGHT_W-1:0] random_weights();
        logic [3:0][WEIGHT_W-1:0] w;
        int r;
        for (int i = 0; i < 4; i++) begin
            r = $urandom_range(9);
            if (r == 0)      w[i] = 8'd0;
            else if (r == 1) w[i] = 8'd255;
            else if (r == 2) w[i] = 8'($urandom);
            else             w[i] = 8'($urandom_range(1, 6));
        end
        return w;
    endfunction

    task automatic send_cmd(input t_in_item cmd, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic settle();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic [3:0] en, input logic [3:0][WEIGHT_W-1:0] wts,
                             input int n, input int put_pct, input bit gaps);
        t_in_item cmd;
        int       q;
        settle();
        write_reg(CFG_QUEUE_ENABLE, {4'b0, en});
        for (int i = 0; i < 4; i++) write_reg(CFG_WEIGHT_Q0 + CFG_IDX_W'(i), wts[i]);
        write_reg(CFG_IDX_W'($urandom_range(5, 7)), 8'($urandom));
        cfg_valid <= 1'b0;
        for (int i = 0; i < n; i++) begin
            q = $urandom_range(3);
            if (en != '0 && $urandom_range(99) < 85) begin
                while (!en[q]) q = $urandom_range(3);
            end
            cmd.func     = ($urandom_range(99) < put_pct) ? FUNC_PUT : FUNC_GET;
            cmd.queue_id = QID_W'(q);
            cmd.message  = $urandom;
            send_cmd(cmd, gaps ? pick_gap() : 0);
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        int put_mix [4];
        put_mix = '{70, 35, 50, 50};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: idle empty get, wake, serve, scan, idle again
        send_cmd(make_cmd(FUNC_GET, 2'd3, 32'hFFFF_FFFF), 0);
        send_cmd(make_cmd(FUNC_PUT, 2'd0, 32'h0000_0000), 0);
        send_cmd(make_cmd(FUNC_PUT, 2'd0, 32'hFFFF_FFFF), 1);
        send_cmd(make_cmd(FUNC_GET, 2'd0, 32'h5555_5555), 0);
        send_cmd(make_cmd(FUNC_GET, 2'd1, 32'hAAAA_AAAA), 0);
        send_cmd(make_cmd(FUNC_GET, 2'd2, 32'h0000_0000), 0);
        send_cmd(make_cmd(FUNC_GET, 2'd3, 32'h0000_0000), 0);
        in_valid <= 1'b0;

        // queue 2 disabled, queue 3 filled past its depth, then a scan onto it
        settle();
        write_reg(CFG_QUEUE_ENABLE, 8'b0000_1011);
        cfg_valid <= 1'b0;
        send_cmd(make_cmd(FUNC_PUT, 2'd2, 32'h5555_5555), 0);
        for (int i = 0; i < 17; i++) begin
            send_cmd(make_cmd(FUNC_PUT, 2'd3, 32'hAAAA_AAAA ^ 32'(i)), 0);
        end
        send_cmd(make_cmd(FUNC_GET, 2'd0, 32'h0000_0000), 0);
        in_valid <= 1'b0;

        run_phase(4'hF, {4{8'd255}}, ITEMS_PER_PHASE, 60, 1'b1);
        run_phase(4'hF, {8'd1, 8'd0, 8'd1, 8'd1}, ITEMS_PER_PHASE, 50, 1'b1);
        run_phase(4'h1, random_weights(), ITEMS_PER_PHASE, 55, 1'b1);
        run_phase(4'h0, random_weights(), 20, 50, 1'b1);
        for (int p = 0; p < 4; p++) begin
            run_phase(4'($urandom_range(1, 15)), random_weights(), ITEMS_PER_PHASE,
                      put_mix[p], p != 2);
        end
        settle();

        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* weighted_round_robin_multi_queue.f */
+incdir+rtl
rtl/wrrmq_pkg.sv
rtl/wrrmq_ram.sv
rtl/wrrmq_pick.sv
rtl/weighted_round_robin_multi_queue.sv
tb/sv/wrrmq_service_checker.sv
tb/sv/testbench.sv
